@@ design/pfr_pkg.sv @@
// Shared types and constants for the position frame receiver.
// Used by pfr_front, pfr_queue, pfr_back and position_frame_receiver.
package pfr_pkg;

  // Frame end status codes
  typedef enum logic [1:0] {
    ST_GOOD = 2'd0,
    ST_CSUM = 2'd1,
    ST_OVER = 2'd2
  } status_e;

  // Decoded position kind
  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_TARGET = 2'd1,
    KIND_LASER  = 2'd2
  } kind_e;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_HEADER_FIRST   = 2'd0;
  localparam logic [1:0] REG_HEADER_SECOND  = 2'd1;
  localparam logic [1:0] REG_TARGET_COMMAND = 2'd2;
  localparam logic [1:0] REG_LASER_COMMAND  = 2'd3;

  // Register reset values
  localparam logic [7:0] RST_HEADER_FIRST   = 8'd170;
  localparam logic [7:0] RST_HEADER_SECOND  = 8'd85;
  localparam logic [7:0] RST_TARGET_COMMAND = 8'd1;
  localparam logic [7:0] RST_LASER_COMMAND  = 8'd2;

  // Framing constants
  localparam int          POS_W          = 9;     // byte position / frame total width
  localparam logic [8:0]  FRAME_OVERHEAD = 9'd5;  // headers, length, command, checksum
  localparam logic [8:0]  CMD_POS        = 9'd3;  // position of the command byte
  localparam logic [7:0]  HEAD_BYTES     = 8'd4;  // payload bytes kept for x and y
  localparam int          HEAD_DEPTH     = 4;

  // Event queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Configuration seen by the front end
  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] target_command;
    logic [7:0] laser_command;
  } pfr_cfg_t;

  // One frame end event
  typedef struct packed {
    status_e           status;
    logic [7:0]        command;
    logic [7:0]        length;
    kind_e             kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } pfr_event_t;

endpackage

@@ design/pfr_front.sv @@
// Front end: header hunt, length/command/payload parse and checksum.
// Emits one pfr_pkg::pfr_event_t per ended frame. Depends on pfr_pkg.
module pfr_front #(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pfr_pkg::pfr_cfg_t   cfg_i,
  input  logic                beat_i,     // byte accepted this cycle
  input  logic [7:0]          rx_byte_i,
  output logic                push_o,
  output pfr_pkg::pfr_event_t event_o
);

  localparam logic [1:0] PH_HUNT1 = 2'd0;
  localparam logic [1:0] PH_HUNT2 = 2'd1;
  localparam logic [1:0] PH_LEN   = 2'd2;
  localparam logic [1:0] PH_BODY  = 2'd3;

  localparam logic [pfr_pkg::POS_W-1:0] MaxBytes = pfr_pkg::POS_W'(MAX_FRAME_BYTES);

  logic [1:0]                phase_q, phase_d;
  logic [pfr_pkg::POS_W-1:0] total_q, total_d;
  logic [pfr_pkg::POS_W-1:0] pos_q, pos_d;
  logic [pfr_pkg::POS_W-1:0] pos_inc;
  logic [7:0]                len_q, len_d;
  logic [7:0]                sum_q, sum_d;
  logic [7:0]                cmd_q, cmd_d;
  logic [7:0]                head_q [pfr_pkg::HEAD_DEPTH];
  logic                      head_we;
  logic [1:0]                head_idx;
  logic                      done, over, check_ok;
  pfr_pkg::status_e          status;
  pfr_pkg::kind_e            kind;

  // Byte parser
  always_comb begin
    phase_d  = phase_q;
    total_d  = total_q;
    pos_d    = pos_q;
    len_d    = len_q;
    sum_d    = sum_q;
    cmd_d    = cmd_q;
    head_we  = 1'b0;
    head_idx = pos_q[1:0];
    push_o   = 1'b0;
    pos_inc  = pos_q + 9'd1;
    done     = (pos_inc >= total_q);
    over     = (pos_inc >= MaxBytes);
    check_ok = (rx_byte_i == sum_q);
    if (beat_i) begin
      unique case (phase_q)
        PH_HUNT1: begin
          if (rx_byte_i == cfg_i.header_first) phase_d = PH_HUNT2;
        end
        PH_HUNT2: begin
          phase_d = (rx_byte_i == cfg_i.header_second) ? PH_LEN : PH_HUNT1;
        end
        PH_LEN: begin
          total_d = {1'b0, rx_byte_i} + pfr_pkg::FRAME_OVERHEAD;
          len_d   = rx_byte_i;
          sum_d   = rx_byte_i;
          pos_d   = pfr_pkg::CMD_POS;
          phase_d = PH_BODY;
        end
        PH_BODY: begin
          pos_d = pos_inc;
          if (!done) begin
            sum_d = sum_q + rx_byte_i;
            if (pos_q == pfr_pkg::CMD_POS) begin
              cmd_d = rx_byte_i;
            end else if (pos_q[8:2] == 7'd1) begin
              // payload bytes 0..3 sit at positions 4..7
              head_we = 1'b1;
            end
          end
          if (done || over) begin
            push_o  = 1'b1;
            phase_d = PH_HUNT1;
            pos_d   = '0;
          end
        end
        default: phase_d = PH_HUNT1;
      endcase
    end
  end

  // Event contents for the ending frame
  always_comb begin
    if (over) begin
      status = pfr_pkg::ST_OVER;
    end else if (!check_ok) begin
      status = pfr_pkg::ST_CSUM;
    end else begin
      status = pfr_pkg::ST_GOOD;
    end
    kind = pfr_pkg::KIND_NONE;
    if (status == pfr_pkg::ST_GOOD && len_q >= pfr_pkg::HEAD_BYTES) begin
      priority if (cmd_q == cfg_i.target_command) begin
        kind = pfr_pkg::KIND_TARGET;
      end else if (cmd_q == cfg_i.laser_command) begin
        kind = pfr_pkg::KIND_LASER;
      end else begin
        kind = pfr_pkg::KIND_NONE;
      end
    end
    event_o.status  = status;
    event_o.command = cmd_q;
    event_o.length  = len_q;
    event_o.kind    = kind;
    if (kind == pfr_pkg::KIND_NONE) begin
      event_o.x = '0;
      event_o.y = '0;
    end else begin
      event_o.x = {head_q[1], head_q[0]};
      event_o.y = {head_q[3], head_q[2]};
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT1;
      total_q <= '0;
      pos_q   <= '0;
      len_q   <= '0;
      sum_q   <= '0;
      cmd_q   <= '0;
    end else begin
      phase_q <= phase_d;
      total_q <= total_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
      cmd_q   <= cmd_d;
    end
  end

  // Payload head bytes, no reset
  always_ff @(posedge clk_i) begin
    if (head_we) head_q[head_idx] <= rx_byte_i;
  end

endmodule

@@ design/pfr_queue.sv @@
// Two-entry event queue between the front end and the back end.
// Depends on pfr_pkg for the event type and depth.
module pfr_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pfr_pkg::pfr_event_t push_data_i,
  input  logic                pop_i,
  output logic                valid_o,
  output logic                full_o,
  output pfr_pkg::pfr_event_t pop_data_o
);

  pfr_pkg::pfr_event_t            mem_q [pfr_pkg::QUEUE_DEPTH];
  logic [pfr_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [pfr_pkg::QCNT_W-1:0]     count_q;

  assign valid_o    = (count_q != '0);
  assign full_o     = (count_q == pfr_pkg::QCNT_W'(pfr_pkg::QUEUE_DEPTH));
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("event queue overrun");

  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("event queue underrun");

endmodule

@@ design/pfr_back.sv @@
// Back end: target hold, pairing, error count and the result register.
// Consumes pfr_pkg::pfr_event_t beats from pfr_queue. Depends on pfr_pkg.
module pfr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                evt_valid_i,
  input  pfr_pkg::pfr_event_t evt_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          frame_status_o,
  output logic [7:0]          command_code_o,
  output logic [7:0]          payload_length_o,
  output logic [1:0]          position_kind_o,
  output logic signed [15:0]  pos_x_o,
  output logic signed [15:0]  pos_y_o,
  output logic                pair_ready_o,
  output logic signed [15:0]  last_target_x_o,
  output logic signed [15:0]  last_target_y_o,
  output logic [15:0]         pair_number_o,
  output logic [15:0]         error_total_o
);

  logic               out_valid_q;
  logic signed [15:0] tgt_x_q, tgt_x_d;
  logic signed [15:0] tgt_y_q, tgt_y_d;
  logic               seen_q, seen_d;
  logic [15:0]        pair_q, pair_d;
  logic [15:0]        err_q, err_d;
  logic               pr;

  // Take the next event when the result register is free or being drained
  assign pop_o       = evt_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;

  // State update for one event
  always_comb begin
    tgt_x_d = tgt_x_q;
    tgt_y_d = tgt_y_q;
    seen_d  = seen_q;
    pair_d  = pair_q;
    err_d   = err_q;
    pr      = 1'b0;
    if (evt_i.status != pfr_pkg::ST_GOOD) err_d = err_q + 16'd1;
    unique case (evt_i.kind)
      pfr_pkg::KIND_TARGET: begin
        tgt_x_d = evt_i.x;
        tgt_y_d = evt_i.y;
        seen_d  = 1'b1;
      end
      pfr_pkg::KIND_LASER: begin
        if (seen_q) begin
          pr     = 1'b1;
          pair_d = pair_q + 16'd1;
        end
      end
      default: ;
    endcase
  end

  // Control and running state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      tgt_x_q     <= '0;
      tgt_y_q     <= '0;
      seen_q      <= 1'b0;
      pair_q      <= '0;
      err_q       <= '0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        tgt_x_q     <= tgt_x_d;
        tgt_y_q     <= tgt_y_d;
        seen_q      <= seen_d;
        pair_q      <= pair_d;
        err_q       <= err_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      frame_status_o   <= 2'(evt_i.status);
      command_code_o   <= evt_i.command;
      payload_length_o <= evt_i.length;
      position_kind_o  <= 2'(evt_i.kind);
      pos_x_o          <= evt_i.x;
      pos_y_o          <= evt_i.y;
      pair_ready_o     <= pr;
      last_target_x_o  <= tgt_x_d;
      last_target_y_o  <= tgt_y_d;
      pair_number_o    <= pair_d;
      error_total_o    <= err_d;
    end
  end

  a_pair_is_laser: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && pair_ready_o) |-> (position_kind_o == 2'(pfr_pkg::KIND_LASER)))
    else $error("pair_ready on a non-laser result");

  a_kind_needs_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && position_kind_o != 2'(pfr_pkg::KIND_NONE))
      |-> (frame_status_o == 2'(pfr_pkg::ST_GOOD)))
    else $error("position decoded on a failed frame");

  a_error_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && evt_i.status != pfr_pkg::ST_GOOD)
      |=> (error_total_o == 16'($past(err_q) + 16'd1)))
    else $error("error total did not advance on a failed frame");

endmodule

@@ design/position_frame_receiver.sv @@
// position_frame_receiver: takes one received byte per beat, every clock unless stalled;
// a frame end produces one result beat via the event queue and the result register.
// The front parser handles one byte per cycle; a two-entry event queue sits between
// it and the result register, and rx stall rises only when that queue is full.
// Four 8-bit registers (headers, target and laser command) at byte addresses 0..12.
module position_frame_receiver #(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // byte input
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  // result output
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         frame_status_o,
  output logic [7:0]         command_code_o,
  output logic [7:0]         payload_length_o,
  output logic [1:0]         position_kind_o,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic               pair_ready_o,
  output logic signed [15:0] last_target_x_o,
  output logic signed [15:0] last_target_y_o,
  output logic [15:0]        pair_number_o,
  output logic [15:0]        error_total_o
);

  pfr_pkg::pfr_cfg_t   cfg_q;
  pfr_pkg::pfr_event_t push_evt, pop_evt;
  logic                cfg_we;
  logic [1:0]          reg_idx;
  logic                beat;
  logic                push, pop, q_valid, q_full;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first   <= pfr_pkg::RST_HEADER_FIRST;
      cfg_q.header_second  <= pfr_pkg::RST_HEADER_SECOND;
      cfg_q.target_command <= pfr_pkg::RST_TARGET_COMMAND;
      cfg_q.laser_command  <= pfr_pkg::RST_LASER_COMMAND;
    end else if (cfg_we) begin
      unique case (reg_idx)
        pfr_pkg::REG_HEADER_FIRST:   cfg_q.header_first   <= pwdata[7:0];
        pfr_pkg::REG_HEADER_SECOND:  cfg_q.header_second  <= pwdata[7:0];
        pfr_pkg::REG_TARGET_COMMAND: cfg_q.target_command <= pwdata[7:0];
        pfr_pkg::REG_LASER_COMMAND:  cfg_q.laser_command  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      pfr_pkg::REG_HEADER_FIRST:   prdata = {24'd0, cfg_q.header_first};
      pfr_pkg::REG_HEADER_SECOND:  prdata = {24'd0, cfg_q.header_second};
      pfr_pkg::REG_TARGET_COMMAND: prdata = {24'd0, cfg_q.target_command};
      pfr_pkg::REG_LASER_COMMAND:  prdata = {24'd0, cfg_q.laser_command};
      default:                     prdata = '0;
    endcase
  end

  // Input beat
  assign in_stall_o = q_full;
  assign beat       = in_valid_i && !in_stall_o;

  pfr_front #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .beat_i    (beat),
    .rx_byte_i (rx_byte_i),
    .push_o    (push),
    .event_o   (push_evt)
  );

  pfr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_evt),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .full_o      (q_full),
    .pop_data_o  (pop_evt)
  );

  pfr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .evt_valid_i      (q_valid),
    .evt_i            (pop_evt),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .frame_status_o   (frame_status_o),
    .command_code_o   (command_code_o),
    .payload_length_o (payload_length_o),
    .position_kind_o  (position_kind_o),
    .pos_x_o          (pos_x_o),
    .pos_y_o          (pos_y_o),
    .pair_ready_o     (pair_ready_o),
    .last_target_x_o  (last_target_x_o),
    .last_target_y_o  (last_target_y_o),
    .pair_number_o    (pair_number_o),
    .error_total_o    (error_total_o)
  );

endmodule

@@ test/tb_position_frame_receiver.sv @@
// Self-checking testbench for position_frame_receiver: byte stream in, frame results out.
// A scoreboard class tracks the deframer state, predicts every result and checks it.
// Depends on design/pfr_pkg.sv and design/position_frame_receiver.sv.
module tb_position_frame_receiver;

  localparam int MAX_FRAME   = 64;
  localparam int PHASE_BYTES = 110;
  localparam int IDLE_LIMIT  = 500;

  // Receiver phases tracked by the predictor
  typedef enum logic [1:0] {
    PH_HUNT_FIRST  = 2'd0,
    PH_HUNT_SECOND = 2'd1,
    PH_LENGTH      = 2'd2,
    PH_BODY        = 2'd3
  } rx_phase_e;

  // One frame result beat
  typedef struct packed {
    pfr_pkg::status_e status;
    logic [7:0]       command;
    logic [7:0]       length;
    pfr_pkg::kind_e   kind;
    logic [15:0]      x;
    logic [15:0]      y;
    logic             pair;
    logic [15:0]      tx;
    logic [15:0]      ty;
    logic [15:0]      pairs;
    logic [15:0]      errors;
  } frame_result_t;

  // Deframer predictor plus queue of expected frame results
  class frame_scoreboard;
    logic [7:0]    hdr_first, hdr_second, tgt_cmd, las_cmd;
    rx_phase_e     phase;
    logic [8:0]    frame_total, position;
    logic [7:0]    sum, command;
    logic [7:0]    head_bytes [4];
    logic [15:0]   held_tx, held_ty, pairs, errors;
    logic          target_seen;
    frame_result_t pending_q [$];
    int            mismatches;

    function new();
      hdr_first   = pfr_pkg::RST_HEADER_FIRST;
      hdr_second  = pfr_pkg::RST_HEADER_SECOND;
      tgt_cmd     = pfr_pkg::RST_TARGET_COMMAND;
      las_cmd     = pfr_pkg::RST_LASER_COMMAND;
      phase       = PH_HUNT_FIRST;
      frame_total = '0;
      position    = '0;
      sum         = '0;
      command     = '0;
      held_tx     = '0;
      held_ty     = '0;
      pairs       = '0;
      errors      = '0;
      target_seen = 1'b0;
      mismatches  = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [7:0] value);
      case (idx)
        pfr_pkg::REG_HEADER_FIRST:   hdr_first  = value;
        pfr_pkg::REG_HEADER_SECOND:  hdr_second = value;
        pfr_pkg::REG_TARGET_COMMAND: tgt_cmd    = value;
        default:                     las_cmd    = value;
      endcase
    endfunction

    // Advance the predictor by one accepted byte beat
    function void note_byte(logic [7:0] b);
      logic [8:0]    at;
      logic          done, good, over;
      frame_result_t r;
      case (phase)
        PH_HUNT_FIRST: begin
          if (b == hdr_first) phase = PH_HUNT_SECOND;
        end
        PH_HUNT_SECOND: begin
          // a wrong second byte is not retried as a first header
          phase = (b == hdr_second) ? PH_LENGTH : PH_HUNT_FIRST;
        end
        PH_LENGTH: begin
          frame_total = {1'b0, b} + pfr_pkg::FRAME_OVERHEAD;
          sum         = b;
          position    = pfr_pkg::CMD_POS;
          phase       = PH_BODY;
        end
        default: begin
          at       = position;
          position = position + 9'd1;
          done     = (position >= frame_total);
          good     = done && (b == sum);
          if (!done) begin
            sum = sum + b;
            if (at == pfr_pkg::CMD_POS) command = b;
            else if (at >= 9'd4 && at < 9'd8) head_bytes[at[1:0]] = b;
          end
          // byte limit wins even over the checksum byte
          over = (position >= MAX_FRAME);
          if (done || over) begin
            r         = '0;
            r.command = command;
            r.length  = 8'(frame_total - pfr_pkg::FRAME_OVERHEAD);
            phase     = PH_HUNT_FIRST;
            position  = '0;
            if (over) begin
              errors   = errors + 16'd1;
              r.status = pfr_pkg::ST_OVER;
            end else if (!good) begin
              errors   = errors + 16'd1;
              r.status = pfr_pkg::ST_CSUM;
            end else begin
              r.status = pfr_pkg::ST_GOOD;
              // target wins when both command registers match
              if (r.length >= pfr_pkg::HEAD_BYTES &&
                  (command == tgt_cmd || command == las_cmd)) begin
                r.x = {head_bytes[1], head_bytes[0]};
                r.y = {head_bytes[3], head_bytes[2]};
                if (command == tgt_cmd) begin
                  r.kind      = pfr_pkg::KIND_TARGET;
                  held_tx     = r.x;
                  held_ty     = r.y;
                  target_seen = 1'b1;
                end else begin
                  r.kind = pfr_pkg::KIND_LASER;
                  if (target_seen) begin
                    r.pair = 1'b1;
                    pairs  = pairs + 16'd1;
                  end
                end
              end
            end
            r.tx     = held_tx;
            r.ty     = held_ty;
            r.pairs  = pairs;
            r.errors = errors;
            pending_q.push_back(r);
          end
        end
      endcase
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] %s mismatch: expected %h, got %h", $time, name, want, got);
      end
    endfunction

    // Check one result beat against the oldest expectation
    function void check_result(frame_result_t got);
      frame_result_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result beat with nothing expected", $time);
      end else begin
        want = pending_q.pop_front();
        compare_field("frame_status",   want.status,  got.status);
        compare_field("command_code",   want.command, got.command);
        compare_field("payload_length", want.length,  got.length);
        compare_field("position_kind",  want.kind,    got.kind);
        compare_field("pos_x",          want.x,       got.x);
        compare_field("pos_y",          want.y,       got.y);
        compare_field("pair_ready",     want.pair,    got.pair);
        compare_field("last_target_x",  want.tx,      got.tx);
        compare_field("last_target_y",  want.ty,      got.ty);
        compare_field("pair_number",    want.pairs,   got.pairs);
        compare_field("error_total",    want.errors,  got.errors);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel, penable, pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata, prdata;
  logic               pready;
  logic               in_valid_i, in_stall_o;
  logic [7:0]         rx_byte_i;
  logic               out_valid_o, out_stall_i;
  logic [1:0]         frame_status_o, position_kind_o;
  logic [7:0]         command_code_o, payload_length_o;
  logic signed [15:0] pos_x_o, pos_y_o, last_target_x_o, last_target_y_o;
  logic               pair_ready_o;
  logic [15:0]        pair_number_o, error_total_o;

  frame_scoreboard sb;
  bit              calm;
  int              rx_count;
  int              idle_cycles;

  position_frame_receiver #(.MAX_FRAME_BYTES(MAX_FRAME)) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .frame_status_o   (frame_status_o),
    .command_code_o   (command_code_o),
    .payload_length_o (payload_length_o),
    .position_kind_o  (position_kind_o),
    .pos_x_o          (pos_x_o),
    .pos_y_o          (pos_y_o),
    .pair_ready_o     (pair_ready_o),
    .last_target_x_o  (last_target_x_o),
    .last_target_y_o  (last_target_y_o),
    .pair_number_o    (pair_number_o),
    .error_total_o    (error_total_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  // Result monitor: every accepted result beat goes to the scoreboard
  always @(posedge clk_i) begin
    frame_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.status  = pfr_pkg::status_e'(frame_status_o);
      got.command = command_code_o;
      got.length  = payload_length_o;
      got.kind    = pfr_pkg::kind_e'(position_kind_o);
      got.x       = pos_x_o;
      got.y       = pos_y_o;
      got.pair    = pair_ready_o;
      got.tx      = last_target_x_o;
      got.ty      = last_target_y_o;
      got.pairs   = pair_number_o;
      got.errors  = error_total_o;
      sb.check_result(got);
    end
  end

  // Watchdog: too many cycles without any beat on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles = idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result-side back-pressure: a random stall, possibly none, before each result beat
  initial begin
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = draw_gap();
      if (n > 0) begin
        @(negedge clk_i) out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // Drive one byte beat after a random gap, hold it until taken
  task automatic push_byte(logic [7:0] b);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    rx_count++;
    sb.note_byte(b);
  endtask

  // Feed filler bytes until the receiver is back to hunting
  task automatic settle();
    while (sb.phase != PH_HUNT_FIRST) push_byte(8'($urandom));
  endtask

  // Full frame; head carries x in its low half and y in its high half
  task automatic send_frame(logic [7:0] cmd, int len, logic [31:0] head, bit bad_sum);
    logic [7:0] sum, b;
    settle();
    push_byte(sb.hdr_first);
    push_byte(sb.hdr_second);
    push_byte(8'(len));
    push_byte(cmd);
    sum = 8'(len) + cmd;
    for (int i = 0; i < len; i++) begin
      b = (i < 4) ? head[8*i +: 8] : 8'($urandom);
      push_byte(b);
      sum = sum + b;
      // long frames are cut off by the byte limit
      if (sb.phase == PH_HUNT_FIRST) return;
    end
    push_byte(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, value};
    @(negedge clk_i) penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_register(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Stop input, drain every expected result, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Mostly well-formed frames with random content, plus noise and broken headers
  task automatic random_traffic(int n);
    int          stop, pick, len;
    logic [7:0]  cmd;
    logic [31:0] head;
    stop = rx_count + n;
    while (rx_count < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) cmd = sb.tgt_cmd;
        else if (pick < 75) cmd = sb.las_cmd;
        else cmd = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 70) len = $urandom_range(0, 8);
        else if (pick < 88) len = $urandom_range(9, 40);
        else if (pick < 95) len = $urandom_range(41, 58);
        else len = $urandom_range(59, 255);
        case ($urandom_range(0, 11))
          0:       head = 32'h7fff_8000;
          1:       head = 32'h8000_7fff;
          2:       head = 32'hffff_ffff;
          3:       head = 32'h0000_0000;
          default: head = $urandom;
        endcase
        send_frame(cmd, len, head, $urandom_range(0, 99) < 12);
      end else if (pick < 86) begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
      end else begin
        // first header followed by a random, usually wrong, second byte
        push_byte(sb.hdr_first);
        push_byte(8'($urandom));
      end
    end
    settle();
  endtask

  task automatic run_phase(logic [7:0] h1, logic [7:0] h2, logic [7:0] tc, logic [7:0] lc,
                           bit quiet);
    wait_idle();
    write_reg(pfr_pkg::REG_HEADER_FIRST, h1);
    write_reg(pfr_pkg::REG_HEADER_SECOND, h2);
    write_reg(pfr_pkg::REG_TARGET_COMMAND, tc);
    write_reg(pfr_pkg::REG_LASER_COMMAND, lc);
    calm = quiet;
    random_traffic(PHASE_BYTES);
  endtask

  initial begin
    logic [7:0] c;
    sb          = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    rx_byte_i   = 8'd0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    calm        = 1'b0;
    rx_count    = 0;
    idle_cycles = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed frames with reset register values
    push_byte(sb.hdr_first);   // second header mismatch, byte equals first header
    push_byte(sb.hdr_first);
    push_byte(sb.hdr_second);  // must not open a frame
    send_frame(sb.tgt_cmd, 4, 32'h7fff_8000, 1'b0);
    send_frame(sb.las_cmd, 4, 32'h0000_ffff, 1'b0);   // pairs with the target
    send_frame(sb.las_cmd, 6, 32'h1234_5678, 1'b1);   // checksum error
    send_frame(sb.tgt_cmd, 3, 32'h00ff_ff00, 1'b0);   // short payload
    send_frame(8'hff, 0, 32'h0, 1'b0);                // other command
    send_frame(8'h00, 8, 32'h8000_7fff, 1'b0);
    send_frame(sb.tgt_cmd, MAX_FRAME - 5, 32'h0101_0101, 1'b0);  // limit on checksum
    send_frame(sb.las_cmd, 255, 32'h0, 1'b0);         // limit mid-payload
    random_traffic(PHASE_BYTES);

    // Register settings, extremes first
    run_phase(8'h00, 8'hff, 8'hff, 8'h00, 1'b1);
    run_phase(8'hff, 8'h00, 8'h00, 8'hff, 1'b0);
    c = 8'($urandom);
    run_phase(8'($urandom), 8'($urandom), c, c, 1'b0);  // equal command codes
    run_phase(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
    run_phase(pfr_pkg::RST_HEADER_FIRST, pfr_pkg::RST_HEADER_SECOND,
              pfr_pkg::RST_TARGET_COMMAND, pfr_pkg::RST_LASER_COMMAND, 1'b0);
    wait_idle();

    if (sb.mismatches == 0 && sb.pending_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

@@ position_frame_receiver.f @@
design/pfr_pkg.sv
design/pfr_front.sv
design/pfr_queue.sv
design/pfr_back.sv
design/position_frame_receiver.sv
test/tb_position_frame_receiver.sv
